/* hdl/spim_pkg.sv */
// Shared types, register codes and the rate table of the SPI master.
`timescale 1ns / 1ps

package spim_pkg;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Register addresses.
  localparam logic [2:0] ADDR_CTL    = 3'd0;
  localparam logic [2:0] ADDR_STATUS = 3'd1;
  localparam logic [2:0] ADDR_DATA   = 3'd2;
  localparam logic [2:0] ADDR_EXT    = 3'd3;
  localparam logic [2:0] ADDR_SEL    = 3'd4;

  // Control register bits.
  localparam int unsigned CTL_IE_BIT  = 7;
  localparam int unsigned CTL_EN_BIT  = 6;
  localparam int unsigned CTL_POL_BIT = 3;
  localparam int unsigned CTL_PHA_BIT = 2;
  localparam logic [7:0]  CTL_MST     = 8'h10;

  // Status register bits that a write of one clears.
  localparam int unsigned ST_SPIF_BIT = 7;
  localparam int unsigned ST_WCOL_BIT = 6;

  // Operation classes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_READ,
    OP_WRITE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] addr;
    logic [7:0] data;
    logic       miso;
  } cmd_t;

  // Divider reload for a rate code; codes above eleven saturate.
  function automatic logic [11:0] rate_reload(input logic [3:0] code);
    logic [11:0] r;
    case (code)
      4'd0:    r = 12'h000;
      4'd1:    r = 12'h001;
      4'd2:    r = 12'h007;
      4'd3:    r = 12'h00f;
      4'd4:    r = 12'h003;
      4'd5:    r = 12'h01f;
      4'd6:    r = 12'h03f;
      4'd7:    r = 12'h07f;
      4'd8:    r = 12'h0ff;
      4'd9:    r = 12'h1ff;
      4'd10:   r = 12'h3ff;
      default: r = 12'h7ff;
    endcase
    return r;
  endfunction

endpackage

/* hdl/spim_ifs.sv */
// Valid/ready channel interfaces for the request and result sides.
`timescale 1ns / 1ps

interface spim_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] reg_addr;
  logic [7:0] write_data;
  logic       miso_in;

  modport source (output valid, req_type, reg_addr, write_data, miso_in, input ready);
  modport sink (input valid, req_type, reg_addr, write_data, miso_in, output ready);
endinterface

interface spim_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       sclk_out;
  logic       mosi_out;
  logic [7:0] select_mask;
  logic       irq_out;

  modport source (output valid, read_data, sclk_out, mosi_out, select_mask, irq_out,
                  input ready);
  modport sink (input valid, read_data, sclk_out, mosi_out, select_mask, irq_out,
                output ready);
endinterface

/* hdl/spim_front.sv */
// Front end: takes request transfers and classifies them into commands.
`timescale 1ns / 1ps

module spim_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [2:0]        reg_addr,
  input  logic [7:0]        write_data,
  input  logic              miso_in,
  output logic              push_valid,
  input  logic              push_ready,
  output spim_pkg::cmd_t    push_cmd
);

  // Map the request code onto an operation; the spare code does nothing.
  always_comb begin
    case (req_type)
      spim_pkg::REQ_TICK:  push_cmd.op = spim_pkg::OP_TICK;
      spim_pkg::REQ_READ:  push_cmd.op = spim_pkg::OP_READ;
      spim_pkg::REQ_WRITE: push_cmd.op = spim_pkg::OP_WRITE;
      default:             push_cmd.op = spim_pkg::OP_NOP;
    endcase
    push_cmd.addr = reg_addr;
    push_cmd.data = write_data;
    push_cmd.miso = miso_in;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

/* hdl/spim_cmd_queue.sv */
// Two-entry command queue between the front end and the engine.
`timescale 1ns / 1ps

module spim_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  spim_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output spim_pkg::cmd_t pop_cmd
);

  spim_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/spim_back.sv */
// Engine: bus registers, FIFOs, serial shifter and the result register.
`timescale 1ns / 1ps

module spim_back #(
  parameter int FIFO_DEPTH  = 4,
  parameter int NUM_SELECTS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  spim_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_data,
  output logic           sclk_out,
  output logic           mosi_out,
  output logic [7:0]     select_mask,
  output logic           irq_out
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
  localparam logic [7:0]    SEL_MASK = 8'((1 << NUM_SELECTS) - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SAMP
  } phase_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  // Architectural state.
  logic [7:0]    control_r, control_nxt;
  logic [7:0]    ext_r, ext_nxt;
  logic [7:0]    sel_r, sel_nxt;
  logic [7:0]    tx_mem_r [FIFO_DEPTH];
  logic [7:0]    rx_mem_r [FIFO_DEPTH];
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  logic [PW-1:0] tx_head_r, tx_head_nxt;
  logic [PW-1:0] tx_tail_r, tx_tail_nxt;
  logic [PW-1:0] rx_head_r, rx_head_nxt;
  logic [PW-1:0] rx_tail_r, rx_tail_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [2:0]    bit_r, bit_nxt;
  phase_t        phase_r, phase_nxt;
  logic [11:0]   div_r, div_nxt;
  logic          sclk_r, sclk_nxt;
  logic          done_r, done_nxt;
  logic          wcol_r, wcol_nxt;
  logic [1:0]    tally_r, tally_nxt;

  // Result register.
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_rdata_r;
  logic          out_sclk_r;
  logic          out_mosi_r;
  logic [7:0]    out_sel_r;
  logic          out_irq_r;

  logic          fire;
  logic          tx_push, tx_pop, rx_push, rx_pop;
  logic [7:0]    rdata;
  logic [7:0]    status;
  logic          cpol;
  logic          ena;

  // A command executes whenever the result register is free or drains now.
  assign cmd_ready = !out_valid_r || out_ready;
  assign fire      = cmd_valid && cmd_ready;

  assign cpol   = control_r[spim_pkg::CTL_POL_BIT];
  assign ena    = (div_r == 12'd0);
  assign status = {done_r, wcol_r, 2'b00, (tx_count_r == FULL_CNT), (tx_count_r == '0),
                   (rx_count_r == FULL_CNT), (rx_count_r == '0)};

  // Next-state logic for one command.
  always_comb begin
    control_nxt = control_r;
    ext_nxt     = ext_r;
    sel_nxt     = sel_r;
    shift_nxt   = shift_r;
    bit_nxt     = bit_r;
    phase_nxt   = phase_r;
    div_nxt     = div_r;
    sclk_nxt    = sclk_r;
    done_nxt    = done_r;
    wcol_nxt    = wcol_r;
    tally_nxt   = tally_r;
    tx_push     = 1'b0;
    tx_pop      = 1'b0;
    rx_push     = 1'b0;
    rx_pop      = 1'b0;
    rdata       = 8'd0;

    if (fire) begin
      case (cmd.op)
        spim_pkg::OP_TICK: begin
          if (control_r[spim_pkg::CTL_EN_BIT]) begin
            // Transfer sequencer: load, lead edge, sample edge.
            case (phase_r)
              PH_IDLE: begin
                bit_nxt  = 3'd7;
                sclk_nxt = cpol;
                if (tx_count_r != '0) begin
                  shift_nxt = tx_mem_r[tx_head_r];
                  tx_pop    = 1'b1;
                  phase_nxt = PH_LEAD;
                  if (control_r[spim_pkg::CTL_PHA_BIT]) begin
                    sclk_nxt = ~cpol;
                  end
                end
              end
              PH_LEAD: begin
                if (ena) begin
                  sclk_nxt  = ~sclk_r;
                  phase_nxt = PH_SAMP;
                end
              end
              default: begin
                if (ena) begin
                  shift_nxt = {shift_r[6:0], cmd.miso};
                  if (bit_r == 3'd0) begin
                    phase_nxt = PH_IDLE;
                    sclk_nxt  = cpol;
                    rx_push   = (rx_count_r != FULL_CNT);
                    // Count completed bytes toward the interrupt.
                    if (tally_r != 2'd0) begin
                      tally_nxt = tally_r - 2'd1;
                    end else begin
                      tally_nxt = ext_r[7:6];
                      done_nxt  = 1'b1;
                    end
                  end else begin
                    bit_nxt   = bit_r - 3'd1;
                    phase_nxt = PH_LEAD;
                    sclk_nxt  = ~sclk_r;
                  end
                end
              end
            endcase
            // Rate divider runs only while a byte is in flight.
            if (phase_r != PH_IDLE && div_r != 12'd0) begin
              div_nxt = div_r - 12'd1;
            end else begin
              div_nxt = spim_pkg::rate_reload({ext_r[1:0], control_r[1:0]});
            end
          end
        end
        spim_pkg::OP_READ: begin
          case (cmd.addr)
            spim_pkg::ADDR_CTL:    rdata = control_r;
            spim_pkg::ADDR_STATUS: rdata = status;
            spim_pkg::ADDR_DATA: begin
              if (rx_count_r != '0) begin
                rdata  = rx_mem_r[rx_head_r];
                rx_pop = 1'b1;
              end
            end
            spim_pkg::ADDR_EXT:    rdata = ext_r;
            spim_pkg::ADDR_SEL:    rdata = sel_r;
            default:               rdata = 8'd0;
          endcase
        end
        spim_pkg::OP_WRITE: begin
          case (cmd.addr)
            spim_pkg::ADDR_CTL: control_nxt = cmd.data | spim_pkg::CTL_MST;
            spim_pkg::ADDR_STATUS: begin
              if (cmd.data[spim_pkg::ST_SPIF_BIT]) begin
                done_nxt = 1'b0;
              end
              if (cmd.data[spim_pkg::ST_WCOL_BIT]) begin
                wcol_nxt = 1'b0;
              end
            end
            spim_pkg::ADDR_DATA: begin
              if (control_r[spim_pkg::CTL_EN_BIT]) begin
                if (tx_count_r == FULL_CNT) begin
                  wcol_nxt = 1'b1;
                end else begin
                  tx_push = 1'b1;
                end
              end
            end
            spim_pkg::ADDR_EXT: ext_nxt = cmd.data;
            spim_pkg::ADDR_SEL: sel_nxt = cmd.data & SEL_MASK;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // FIFO pointers and fill counts.
    tx_head_nxt  = tx_pop ? ptr_inc(tx_head_r) : tx_head_r;
    tx_tail_nxt  = tx_push ? ptr_inc(tx_tail_r) : tx_tail_r;
    rx_head_nxt  = rx_pop ? ptr_inc(rx_head_r) : rx_head_r;
    rx_tail_nxt  = rx_push ? ptr_inc(rx_tail_r) : rx_tail_r;
    tx_count_nxt = tx_count_r;
    rx_count_nxt = rx_count_r;
    if (tx_push) begin
      tx_count_nxt = tx_count_r + CW'(1);
    end else if (tx_pop) begin
      tx_count_nxt = tx_count_r - CW'(1);
    end
    if (rx_push) begin
      rx_count_nxt = rx_count_r + CW'(1);
    end else if (rx_pop) begin
      rx_count_nxt = rx_count_r - CW'(1);
    end

    // While disabled the engine stays parked and both FIFOs stay empty.
    if (fire && !control_nxt[spim_pkg::CTL_EN_BIT]) begin
      phase_nxt    = PH_IDLE;
      bit_nxt      = 3'd0;
      shift_nxt    = 8'd0;
      sclk_nxt     = 1'b0;
      tx_count_nxt = '0;
      rx_count_nxt = '0;
      tx_head_nxt  = '0;
      tx_tail_nxt  = '0;
      rx_head_nxt  = '0;
      rx_tail_nxt  = '0;
      tally_nxt    = ext_nxt[7:6];
      div_nxt      = spim_pkg::rate_reload({ext_nxt[1:0], control_nxt[1:0]});
    end

    out_valid_nxt = fire || (out_valid_r && !out_ready);
  end

  // State, sequencer and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= spim_pkg::CTL_MST;
      ext_r       <= 8'd0;
      sel_r       <= 8'd0;
      tx_count_r  <= '0;
      rx_count_r  <= '0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      shift_r     <= 8'd0;
      bit_r       <= 3'd0;
      phase_r     <= PH_IDLE;
      div_r       <= 12'd0;
      sclk_r      <= 1'b0;
      done_r      <= 1'b0;
      wcol_r      <= 1'b0;
      tally_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      control_r   <= control_nxt;
      ext_r       <= ext_nxt;
      sel_r       <= sel_nxt;
      tx_count_r  <= tx_count_nxt;
      rx_count_r  <= rx_count_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      shift_r     <= shift_nxt;
      bit_r       <= bit_nxt;
      phase_r     <= phase_nxt;
      div_r       <= div_nxt;
      sclk_r      <= sclk_nxt;
      done_r      <= done_nxt;
      wcol_r      <= wcol_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (tx_push) begin
      tx_mem_r[tx_tail_r] <= cmd.data;
    end
    if (rx_push) begin
      rx_mem_r[rx_tail_r] <= shift_nxt;
    end
    if (fire) begin
      out_rdata_r <= rdata;
      out_sclk_r  <= sclk_nxt;
      out_mosi_r  <= shift_nxt[7];
      out_sel_r   <= sel_nxt;
      out_irq_r   <= done_nxt && control_nxt[spim_pkg::CTL_IE_BIT];
    end
  end

  assign out_valid   = out_valid_r;
  assign read_data   = out_rdata_r;
  assign sclk_out    = out_sclk_r;
  assign mosi_out    = out_mosi_r;
  assign select_mask = out_sel_r;
  assign irq_out     = out_irq_r;

endmodule

/* hdl/spi_master_with_fifo_registers.sv */
// Top level of the byte-wide SPI master with transmit and receive FIFOs.
//
// The request channel (in_ch) carries one item per transfer: a clock tick
// that samples MISO, a bus read, or a bus write of one of five registers
// (control, status, data, extension, slave select). Every request gives
// exactly one result transfer on out_ch with the read byte (zero unless a
// read), the serial clock and MOSI levels, the select mask and the
// interrupt line as they stand after that request.
// Requests are classified by the front end and held in a two-entry command
// queue; the engine executes one command per cycle into a result register
// while that register is free or draining. A request passes through the
// queue and the result register before its result is valid. The sustained
// rate is one request per cycle while results are taken. The serial divider
// counts down by one on each enabled tick request while a byte is in flight
// and reloads otherwise. Reset (rst_n low, synchronous) leaves the core
// disabled with only the master bit set in control, both FIFOs empty and no
// result pending. When the result receiver stalls, the result register
// holds, the queue fills and in_ch.ready drops until results drain.
`timescale 1ns / 1ps

module spi_master_with_fifo_registers #(
  parameter int FIFO_DEPTH  = 4,
  parameter int NUM_SELECTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  spim_in_if.sink    in_ch,
  spim_out_if.source out_ch
);

  logic           push_valid, push_ready;
  spim_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  spim_pkg::cmd_t pop_cmd;

  // Request classification.
  spim_front u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .req_type   (in_ch.req_type),
    .reg_addr   (in_ch.reg_addr),
    .write_data (in_ch.write_data),
    .miso_in    (in_ch.miso_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue.
  spim_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Register file, FIFOs and serial engine.
  spim_back #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .NUM_SELECTS (NUM_SELECTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_cmd),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .read_data   (out_ch.read_data),
    .sclk_out    (out_ch.sclk_out),
    .mosi_out    (out_ch.mosi_out),
    .select_mask (out_ch.select_mask),
    .irq_out     (out_ch.irq_out)
  );

endmodule

/* tb/spi_master_with_fifo_registers_tb.sv */
// Self-checking testbench for the SPI master with register file and FIFOs.
`timescale 1ns / 1ps

module spi_master_with_fifo_registers_tb;

  localparam int CLK_HALF     = 5;
  localparam int FIFO_DEPTH   = 4;
  localparam int NUM_SELECTS  = 8;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;

  // Request code that the block treats as no operation.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Addresses with no register behind them.
  localparam logic [2:0] ADDR_UNUSED_LO = 3'd5;
  localparam logic [2:0] ADDR_UNUSED_HI = 3'd7;

  localparam logic [7:0] SEL_KEEP = 8'((1 << NUM_SELECTS) - 1);

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_LEAD,
    ENG_SAMPLE
  } engine_phase_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       sclk;
    logic       mosi;
    logic [7:0] sel;
    logic       irq;
  } spi_result_t;

  logic clk = 1'b0;
  logic rst_n;

  spim_in_if  in_ch ();
  spim_out_if out_ch ();

  spi_master_with_fifo_registers #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .NUM_SELECTS(NUM_SELECTS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Free-running clock.
  always #CLK_HALF clk = ~clk;

  // Predicted state of the block, starting from its reset values.
  logic [7:0]    ctl_reg   = spim_pkg::CTL_MST;
  logic [7:0]    ext_reg   = '0;
  logic [7:0]    sel_reg   = '0;
  logic [7:0]    tx_bytes[$];
  logic [7:0]    rx_bytes[$];
  logic [7:0]    shift_reg = '0;
  logic [3:0]    bit_cnt   = '0;
  engine_phase_t eng_phase = ENG_IDLE;
  logic [11:0]   div_cnt   = '0;
  logic          sclk_lvl  = 1'b0;
  logic          spif      = 1'b0;
  logic          wcol      = 1'b0;
  logic [1:0]    irq_tally = '0;

  // Results still owed by the block, oldest first.
  spi_result_t pending_results[$];

  int n_requests;
  int n_checked;
  int n_errors;
  int n_bytes_shifted;
  int n_rx_dropped;
  int n_wcol;
  bit idle_on   = 1'b1;
  bit stall_req = 1'b0;

  // Divider reload for a rate code: a power of two minus one, codes above
  // eleven held at the slowest rate.
  function automatic logic [11:0] div_reload(input logic [3:0] code);
    int exp2;
    case (code)
      4'd2, 4'd3: exp2 = int'(code) + 1;
      4'd4:       exp2 = 2;
      default:    exp2 = (code > 4'd11) ? 11 : int'(code);
    endcase
    return 12'((1 << exp2) - 1);
  endfunction

  // Apply one request to the predicted state and return the result it gives.
  function automatic spi_result_t spi_predict(input logic [1:0] req, input logic [2:0] addr,
                                              input logic [7:0] data, input logic miso);
    spi_result_t r;
    logic        div_zero;
    logic        was_busy;
    logic        cpol;
    r = '0;
    case (req)
      spim_pkg::REQ_TICK: if (ctl_reg[spim_pkg::CTL_EN_BIT]) begin
        div_zero = (div_cnt == 12'd0);
        was_busy = (eng_phase != ENG_IDLE);
        cpol     = ctl_reg[spim_pkg::CTL_POL_BIT];
        case (eng_phase)
          ENG_IDLE: begin
            bit_cnt  = 4'd7;
            sclk_lvl = cpol;
            if (tx_bytes.size() != 0) begin
              shift_reg = tx_bytes.pop_front();
              eng_phase = ENG_LEAD;
              if (ctl_reg[spim_pkg::CTL_PHA_BIT]) sclk_lvl = ~cpol;
            end
          end
          ENG_LEAD: if (div_zero) begin
            sclk_lvl  = ~sclk_lvl;
            eng_phase = ENG_SAMPLE;
          end
          default: if (div_zero) begin
            shift_reg = {shift_reg[6:0], miso};
            if (bit_cnt == 4'd0) begin
              // Byte complete: store it if there is room, then count toward the flag.
              eng_phase = ENG_IDLE;
              sclk_lvl  = cpol;
              n_bytes_shifted++;
              if (rx_bytes.size() < FIFO_DEPTH) rx_bytes.push_back(shift_reg);
              else n_rx_dropped++;
              if (irq_tally != 2'd0) begin
                irq_tally = irq_tally - 2'd1;
              end else begin
                irq_tally = ext_reg[7:6];
                spif      = 1'b1;
              end
            end else begin
              bit_cnt   = bit_cnt - 4'd1;
              eng_phase = ENG_LEAD;
              sclk_lvl  = ~sclk_lvl;
            end
          end
        endcase
        if (was_busy && div_cnt != 12'd0) div_cnt = div_cnt - 12'd1;
        else div_cnt = div_reload({ext_reg[1:0], ctl_reg[1:0]});
      end
      spim_pkg::REQ_READ: begin
        case (addr)
          spim_pkg::ADDR_CTL:    r.rdata = ctl_reg;
          spim_pkg::ADDR_STATUS: r.rdata = {spif, wcol, 2'b00,
                                            tx_bytes.size() >= FIFO_DEPTH,
                                            tx_bytes.size() == 0,
                                            rx_bytes.size() >= FIFO_DEPTH,
                                            rx_bytes.size() == 0};
          spim_pkg::ADDR_DATA:   if (rx_bytes.size() != 0) r.rdata = rx_bytes.pop_front();
          spim_pkg::ADDR_EXT:    r.rdata = ext_reg;
          spim_pkg::ADDR_SEL:    r.rdata = sel_reg;
          default:               ;
        endcase
      end
      spim_pkg::REQ_WRITE: begin
        case (addr)
          spim_pkg::ADDR_CTL:    ctl_reg = data | spim_pkg::CTL_MST;
          spim_pkg::ADDR_STATUS: begin
            if (data[spim_pkg::ST_SPIF_BIT]) spif = 1'b0;
            if (data[spim_pkg::ST_WCOL_BIT]) wcol = 1'b0;
          end
          spim_pkg::ADDR_DATA:   if (ctl_reg[spim_pkg::CTL_EN_BIT]) begin
            if (tx_bytes.size() >= FIFO_DEPTH) begin
              wcol = 1'b1;
              n_wcol++;
            end else begin
              tx_bytes.push_back(data);
            end
          end
          spim_pkg::ADDR_EXT:    ext_reg = data;
          spim_pkg::ADDR_SEL:    sel_reg = data & SEL_KEEP;
          default:               ;
        endcase
      end
      default: ;
    endcase

    // While disabled the engine and both FIFOs are held clear.
    if (!ctl_reg[spim_pkg::CTL_EN_BIT]) begin
      eng_phase = ENG_IDLE;
      bit_cnt   = '0;
      shift_reg = '0;
      sclk_lvl  = 1'b0;
      tx_bytes.delete();
      rx_bytes.delete();
      irq_tally = ext_reg[7:6];
      div_cnt   = div_reload({ext_reg[1:0], ctl_reg[1:0]});
    end

    r.sclk = sclk_lvl;
    r.mosi = shift_reg[7];
    r.sel  = sel_reg;
    r.irq  = spif & ctl_reg[spim_pkg::CTL_IE_BIT];
    return r;
  endfunction

  // Offer one request, wait for its transfer and record what it should give.
  task automatic send_req(input logic [1:0] req, input logic [2:0] addr,
                          input logic [7:0] data, input logic miso);
    if (idle_on && $urandom_range(99) < 4) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.reg_addr   <= addr;
    in_ch.write_data <= data;
    in_ch.miso_in    <= miso;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(spi_predict(req, addr, data, miso));
    n_requests++;
  endtask

  // Register access at the extremes, unused addresses, the no-op request,
  // data writes while disabled, a full transmit FIFO and the slowest rate.
  task automatic test_register_file();
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_CTL,    8'h00, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL,    8'h00, 1'b0);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_CTL,    8'hff, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_EXT,    8'hff, 1'b1);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_EXT,    8'h00, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_SEL,    8'hff, 1'b0);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_SEL,    8'h00, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_SEL,    8'h00, 1'b1);
    send_req(spim_pkg::REQ_WRITE, ADDR_UNUSED_HI,        8'hff, 1'b1);
    send_req(spim_pkg::REQ_READ,  ADDR_UNUSED_LO,        8'h00, 1'b0);
    send_req(REQ_NONE,            spim_pkg::ADDR_DATA,   8'hff, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'h5a, 1'b0);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_STATUS, 8'h00, 1'b0);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_DATA,   8'h00, 1'b0);
    // Rate code fifteen, enabled with every control bit set.
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_EXT,    8'h03, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL,    8'hff, 1'b0);
    // The fifth write finds the transmit FIFO full.
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'h00, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'hff, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'h81, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'h7e, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA,   8'h55, 1'b0);
    send_req(spim_pkg::REQ_READ,  spim_pkg::ADDR_STATUS, 8'h00, 1'b1);
    send_req(spim_pkg::REQ_TICK,  spim_pkg::ADDR_CTL,    8'h00, 1'b1);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_STATUS, 8'hff, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL,    8'h00, 1'b1);
  endtask

  // Configure, load bytes, clock them through and read them back, with
  // random content, random noise and the occasional mid-byte rate change.
  task automatic test_serial_transfers(input int upto);
    int          pick;
    int          n_bytes;
    int          n_ticks;
    int          n_reads;
    logic [3:0]  code;
    logic [7:0]  ctl_val;
    logic [7:0]  ext_val;
    logic [11:0] reload;
    while (n_requests < upto) begin
      // Mostly fast rates; now and then a slow one that only gets partway.
      pick = $urandom_range(99);
      if (pick < 60) code = 4'd0;
      else if (pick < 80) code = 4'd1;
      else if (pick < 90) code = 4'd4;
      else if ($urandom_range(1)) code = 4'($urandom_range(15, 12));
      else code = 4'($urandom_range(11, 2));
      reload = div_reload(code);

      ext_val      = 8'($urandom);
      ext_val[1:0] = code[3:2];
      send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_EXT, ext_val, 1'($urandom));
      if ($urandom_range(99) < 30) begin
        send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_SEL, 8'($urandom), 1'($urandom));
      end
      ctl_val                       = 8'($urandom);
      ctl_val[spim_pkg::CTL_EN_BIT] = 1'b1;
      ctl_val[1:0]                  = code[1:0];
      send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL, ctl_val, 1'($urandom));

      // Fill the transmit FIFO, sometimes past its depth.
      n_bytes = (reload > 12'd3) ? 1 : $urandom_range(4, 1);
      if ($urandom_range(99) < 10) n_bytes = FIFO_DEPTH + 2;
      repeat (n_bytes) begin
        send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA, 8'($urandom), 1'($urandom));
      end

      if (reload > 12'd3) begin
        n_ticks = $urandom_range(40, 10);
      end else begin
        n_ticks = ((n_bytes < FIFO_DEPTH) ? n_bytes : FIFO_DEPTH) *
                  (16 * (int'(reload) + 1) + 1) + 2;
      end
      for (int i = 0; i < n_ticks; i++) begin
        if (i == n_ticks / 2 && $urandom_range(99) < 15) begin
          ctl_val[1:0] = 2'($urandom);
          send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL, ctl_val, 1'($urandom));
        end else if ($urandom_range(99) < 8) begin
          send_req($urandom_range(1) ? spim_pkg::REQ_READ : REQ_NONE, 3'($urandom),
                   8'($urandom), 1'($urandom));
        end else begin
          send_req(spim_pkg::REQ_TICK, 3'($urandom), 8'($urandom), 1'($urandom));
        end
      end

      // Drain some of the received bytes; leaving some lets the FIFO overflow.
      n_reads = $urandom_range(5, 0);
      repeat (n_reads) begin
        send_req(spim_pkg::REQ_READ, spim_pkg::ADDR_DATA, 8'($urandom), 1'($urandom));
      end
      send_req(spim_pkg::REQ_READ, spim_pkg::ADDR_STATUS, 8'($urandom), 1'($urandom));
      send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_STATUS, 8'($urandom), 1'($urandom));

      if ($urandom_range(99) < 25) begin
        ctl_val[spim_pkg::CTL_EN_BIT] = 1'b0;
        send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL, ctl_val, 1'($urandom));
      end
      if ($urandom_range(99) < 15) begin
        repeat (6) send_req(2'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_EXT, 8'h00, 1'b0);
    send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_CTL, 8'h40, 1'b0);
    repeat (3) send_req(spim_pkg::REQ_WRITE, spim_pkg::ADDR_DATA, 8'($urandom), 1'b0);
    stall_req = 1'b1;
    repeat (40) send_req(spim_pkg::REQ_TICK, spim_pkg::ADDR_CTL, 8'($urandom), 1'($urandom));
    repeat (4) send_req(spim_pkg::REQ_READ, spim_pkg::ADDR_DATA, 8'h00, 1'b0);
  endtask

  // Result side: check each transfer, then choose ready for the next cycle.
  initial begin : result_sink
    spi_result_t want;
    spi_result_t got;
    int          stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.rdata = out_ch.read_data;
        got.sclk  = out_ch.sclk_out;
        got.mosi  = out_ch.mosi_out;
        got.sel   = out_ch.select_mask;
        got.irq   = out_ch.irq_out;
        n_checked++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("Unexpected result: rdata=%02h sclk=%b mosi=%b sel=%02h irq=%b",
                     got.rdata, got.sclk, got.mosi, got.sel, got.irq);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.rdata !== want.rdata || got.sclk !== want.sclk ||
              got.mosi !== want.mosi || got.sel !== want.sel || got.irq !== want.irq) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("Mismatch at %0t: expected rdata=%02h sclk=%b mosi=%b sel=%02h irq=%b",
                       $realtime, want.rdata, want.sclk, want.mosi, want.sel, want.irq);
              $display("                 got      rdata=%02h sclk=%b mosi=%b sel=%02h irq=%b",
                       got.rdata, got.sclk, got.mosi, got.sel, got.irq);
            end
          end
        end
      end
      if (stall_req) begin
        stall_left = STALL_CYCLES;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= spim_pkg::REQ_TICK;
    in_ch.reg_addr   <= spim_pkg::ADDR_CTL;
    in_ch.write_data <= 8'h00;
    in_ch.miso_in    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_register_file();
    test_serial_transfers(300);
    // A long stretch with neither side idling.
    idle_on = 1'b0;
    test_serial_transfers(550);
    idle_on = 1'b1;
    test_output_stall();
    test_serial_transfers(900);
    in_ch.valid <= 1'b0;

    // Let the last results arrive, then allow a few more cycles for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests, %0d results checked, %0d bytes shifted by the engine.",
             n_requests, n_checked, n_bytes_shifted);
    $display("Summary: %0d writes to a full transmit FIFO, %0d bytes dropped at a full %s",
             n_wcol, n_rx_dropped, "receive FIFO.");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
